// ===== rtl/dsc_pkg.sv =====
// Shared types, constants and codes for the disk sector checker.
package dsc_pkg;

    // Default sector layout.
    localparam int ADDR_AREA_BYTES_DEF = 8;
    localparam int DATA_AREA_BYTES_DEF = 263;
    localparam int SECTOR_BYTES_DEF    = 256;

    // Field widths.
    localparam int BYTE_W      = 8;
    localparam int HEADS_W     = 5;
    localparam int SPT_W       = 8;
    localparam int CYL_W       = 16;
    localparam int STATUS_W    = 2;
    localparam int LBA_W       = 27;
    localparam int IN_TDATA_W  = 8;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 40;
    localparam int OUT_TUSER_W = 1;

    // Check polynomials, both MSB first with an all-ones start value.
    localparam int             HDR_CRC_W = 16;
    localparam logic [15:0]    HDR_POLY  = 16'h1021;
    localparam int             DAT_CRC_W = 48;
    localparam logic [47:0]    DAT_POLY  = 48'h100B_0001_100B;

    // A sector byte of all ones marks a spare sector.
    localparam logic [BYTE_W-1:0] SPARE_MARK = 8'hFF;

    // LBA arithmetic: the accumulator holds the widest unsaturated product.
    localparam int               LBA_ACC_W = 29;
    localparam logic [LBA_W-1:0] LBA_MAX   = {LBA_W{1'b1}};
    localparam int               LBA_MUL_W = 8;
    localparam int               LBA_STEP_W = 3;

    // Configuration port.
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 8;
    localparam logic [CFG_INDEX_W-1:0] REG_HEAD_COUNT        = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SECTORS_PER_TRACK = 1'd1;
    localparam logic [HEADS_W-1:0]     HEAD_COUNT_RESET      = 5'd8;
    localparam logic [SPT_W-1:0]       SPT_RESET             = 8'd34;

    // Outcome of the address area.
    typedef enum logic [1:0] {
        VERDICT_NONE  = 2'd0,
        VERDICT_BAD   = 2'd1,
        VERDICT_GOOD  = 2'd2,
        VERDICT_SPARE = 2'd3
    } verdict_t;

    // Sector status reported in the final beat.
    typedef enum logic [1:0] {
        STATUS_OK          = 2'd0,
        STATUS_BAD_HEADER  = 2'd1,
        STATUS_BAD_DATA    = 2'd2,
        STATUS_SPARE       = 2'd3
    } status_t;

    // Result kinds carried on the master tuser.
    localparam logic RESULT_PAYLOAD = 1'b0;
    localparam logic RESULT_STATUS  = 1'b1;

    // Main sequencer.
    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_SHIFT = 2'd1,
        ST_LBA   = 2'd2,
        ST_EMIT  = 2'd3
    } ctrl_state_t;

    // LBA shift-and-add sequencer.
    typedef enum logic [1:0] {
        LBA_IDLE    = 2'd0,
        LBA_STAGE_A = 2'd1,
        LBA_STAGE_B = 2'd2
    } lba_state_t;

    // Operands handed to the LBA unit.
    typedef struct packed {
        logic [CYL_W-1:0]   cylinder;
        logic [BYTE_W-1:0]  head;
        logic [BYTE_W-1:0]  sector;
        logic [HEADS_W-1:0] head_count;
        logic [SPT_W-1:0]   sectors_per_track;
    } lba_operands_t;

endpackage

// ===== rtl/disk_sector_check_and_lba_top.sv =====
// Top level of the disk sector checker: byte sequencing, field capture and results.
//
// The block takes one sector byte per slave beat, passes it bit by bit through
// a CRC-16 (address area) or CRC-48 (data area) register, and returns payload
// bytes of a sector with a good header and then one status beat per sector.
// A mark byte or a byte outside the open area is only accepted; any other
// byte is accepted and then shifted into its CRC register bit by bit, and
// passes an emit state as well when it yields a beat or closes the address
// area. The last data byte also runs the LBA shift-and-add unit (shift steps
// for both stages, then a registered done flag) before its status beat. The
// bit serial CRC registers set the byte rate. A result beat is held in a
// single output register; while that register is still full, a new result
// waits for the master side to take the old one, with the slave side not ready.
module disk_sector_check_and_lba_top #(
    parameter int ADDR_AREA_BYTES = dsc_pkg::ADDR_AREA_BYTES_DEF,
    parameter int DATA_AREA_BYTES = dsc_pkg::DATA_AREA_BYTES_DEF,
    parameter int SECTOR_BYTES    = dsc_pkg::SECTOR_BYTES_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Slave side: tdata = byte_value; tuser = area (bit 0), first_of_area (bit 1).
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [dsc_pkg::IN_TDATA_W-1:0]      s_tdata,
    input  logic [dsc_pkg::IN_TUSER_W-1:0]      s_tuser,
    // Master side: tdata = payload_byte [7:0], status [9:8], lba [36:10], zero fill.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [dsc_pkg::OUT_TDATA_W-1:0]     m_tdata,
    // Master tuser = result_kind.
    output logic [dsc_pkg::OUT_TUSER_W-1:0]     m_tuser,
    // Configuration writes.
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [dsc_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [dsc_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int POS_MAX0 = (ADDR_AREA_BYTES > DATA_AREA_BYTES) ?
                              ADDR_AREA_BYTES : DATA_AREA_BYTES;
    localparam int POS_MAX  = (POS_MAX0 > SECTOR_BYTES) ? POS_MAX0 : SECTOR_BYTES;
    localparam int POS_W    = $clog2(POS_MAX + 1);
    localparam int BW       = dsc_pkg::BYTE_W;

    localparam logic [POS_W-1:0] ADDR_LAST   = POS_W'(ADDR_AREA_BYTES - 1);
    localparam logic [POS_W-1:0] DATA_LAST   = POS_W'(DATA_AREA_BYTES - 1);
    localparam logic [POS_W-1:0] PAYLOAD_END = POS_W'(SECTOR_BYTES);
    localparam logic [POS_W-1:0] POS_CYL_HI  = POS_W'(1);
    localparam logic [POS_W-1:0] POS_CYL_LO  = POS_W'(2);
    localparam logic [POS_W-1:0] POS_HEAD    = POS_W'(3);
    localparam logic [POS_W-1:0] POS_SECTOR  = POS_W'(4);

    dsc_pkg::ctrl_state_t state_reg, state_next;
    dsc_pkg::verdict_t    verdict_reg, verdict_next;

    logic [2:0]                    bit_cnt_reg, bit_cnt_next;
    logic [BW-1:0]                 shift_reg, shift_next;
    logic [BW-1:0]                 byte_reg, byte_next;
    logic                          pend_area_reg, pend_area_next;
    logic                          pend_last_reg, pend_last_next;
    logic                          pend_payload_reg, pend_payload_next;
    logic [POS_W-1:0]              pos_reg, pos_next;
    logic                          open_area_reg, open_area_next;
    logic [dsc_pkg::CYL_W-1:0]     cyl_reg, cyl_next;
    logic [BW-1:0]                 head_reg, head_next;
    logic [BW-1:0]                 sect_reg, sect_next;
    logic [dsc_pkg::HEADS_W-1:0]   head_count_reg, head_count_next;
    logic [dsc_pkg::SPT_W-1:0]     spt_reg, spt_next;
    logic                          m_tvalid_reg, m_tvalid_next;
    logic [dsc_pkg::OUT_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [dsc_pkg::OUT_TUSER_W-1:0] m_tuser_reg, m_tuser_next;

    logic                   in_accept;
    logic [BW-1:0]          in_byte;
    logic                   in_area;
    logic                   in_first;
    logic                   in_live;
    logic                   at_addr_last;
    logic                   at_data_last;
    logic                   last_bit;
    logic                   out_free;
    logic                   hdr_init;
    logic                   dat_init;
    logic                   hdr_shift;
    logic                   dat_shift;
    logic                   hdr_zero;
    logic                   dat_zero;
    logic                   lba_start;
    logic                   lba_done;
    logic                   out_load;
    logic                   verdict_set;
    logic [dsc_pkg::LBA_W-1:0] lba_value;
    dsc_pkg::lba_operands_t lba_ops;
    dsc_pkg::status_t       status_val;

    // Slave beat decode.
    assign in_accept    = s_tvalid && s_tready;
    assign in_byte      = s_tdata[BW-1:0];
    assign in_area      = s_tuser[0];
    assign in_first     = s_tuser[1];
    assign in_live      = !in_first && (pos_reg != {POS_W{1'b0}}) &&
                          (in_area == open_area_reg);
    assign at_addr_last = (pos_reg >= ADDR_LAST);
    assign at_data_last = (pos_reg >= DATA_LAST);
    assign last_bit     = (bit_cnt_reg == 3'd7);
    assign out_free     = !m_tvalid_reg || m_tready;
    assign cfg_ready    = 1'b1;

    // Next state of the sequencer.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            dsc_pkg::ST_IDLE: begin
                if (in_accept && in_live) begin
                    state_next = dsc_pkg::ST_SHIFT;
                end
            end
            dsc_pkg::ST_SHIFT: begin
                if (last_bit) begin
                    if (pend_area_reg && pend_last_reg) begin
                        state_next = dsc_pkg::ST_LBA;
                    end else if (pend_payload_reg || (!pend_area_reg && pend_last_reg)) begin
                        state_next = dsc_pkg::ST_EMIT;
                    end else begin
                        state_next = dsc_pkg::ST_IDLE;
                    end
                end
            end
            dsc_pkg::ST_LBA: begin
                if (lba_done) begin
                    state_next = dsc_pkg::ST_EMIT;
                end
            end
            dsc_pkg::ST_EMIT: begin
                if (!pend_area_reg || out_free) begin
                    state_next = dsc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = dsc_pkg::ST_IDLE;
            end
        endcase
    end

    // Controls decoded from the sequencer state.
    always_comb begin
        s_tready    = (state_reg == dsc_pkg::ST_IDLE);
        hdr_init    = in_accept && in_first && !in_area;
        dat_init    = in_accept && in_first && in_area;
        hdr_shift   = (state_reg == dsc_pkg::ST_SHIFT) && !pend_area_reg;
        dat_shift   = (state_reg == dsc_pkg::ST_SHIFT) && pend_area_reg;
        lba_start   = (state_reg == dsc_pkg::ST_SHIFT) && last_bit &&
                      pend_area_reg && pend_last_reg;
        out_load    = (state_reg == dsc_pkg::ST_EMIT) && pend_area_reg && out_free;
        verdict_set = (state_reg == dsc_pkg::ST_EMIT) && !pend_area_reg;
    end

    // Final status in priority order: bad header, spare, bad data, ok.
    always_comb begin
        case (verdict_reg)
            dsc_pkg::VERDICT_GOOD:  status_val = dat_zero ? dsc_pkg::STATUS_OK :
                                                            dsc_pkg::STATUS_BAD_DATA;
            dsc_pkg::VERDICT_SPARE: status_val = dsc_pkg::STATUS_SPARE;
            default:                status_val = dsc_pkg::STATUS_BAD_HEADER;
        endcase
    end

    // Register next values.
    always_comb begin
        bit_cnt_next      = bit_cnt_reg;
        shift_next        = shift_reg;
        byte_next         = byte_reg;
        pend_area_next    = pend_area_reg;
        pend_last_next    = pend_last_reg;
        pend_payload_next = pend_payload_reg;
        pos_next          = pos_reg;
        open_area_next    = open_area_reg;
        cyl_next          = cyl_reg;
        head_next         = head_reg;
        sect_next         = sect_reg;
        verdict_next      = verdict_reg;
        head_count_next   = head_count_reg;
        spt_next          = spt_reg;
        m_tvalid_next     = m_tvalid_reg;
        m_tdata_next      = m_tdata_reg;
        m_tuser_next      = m_tuser_reg;

        // Configuration writes; indexes past the list are ignored.
        if (cfg_valid && cfg_ready) begin
            if (cfg_index == dsc_pkg::REG_HEAD_COUNT) begin
                head_count_next = cfg_data[dsc_pkg::HEADS_W-1:0];
            end else if (cfg_index == dsc_pkg::REG_SECTORS_PER_TRACK) begin
                spt_next = cfg_data[dsc_pkg::SPT_W-1:0];
            end
        end

        // A mark opens its area; an address mark forgets the last verdict.
        if (in_accept && in_first) begin
            open_area_next = in_area;
            pos_next       = POS_W'(1);
            if (!in_area) begin
                verdict_next = dsc_pkg::VERDICT_NONE;
            end
        end else if (in_accept && in_live) begin
            shift_next     = in_byte;
            byte_next      = in_byte;
            pend_area_next = in_area;
            bit_cnt_next   = 3'd0;
            if (!in_area) begin
                case (pos_reg)
                    POS_CYL_HI: cyl_next[dsc_pkg::CYL_W-1:BW] = in_byte;
                    POS_CYL_LO: cyl_next[BW-1:0]              = in_byte;
                    POS_HEAD:   head_next                     = in_byte;
                    POS_SECTOR: sect_next                     = in_byte;
                    default:    ;
                endcase
                pend_last_next    = at_addr_last;
                pend_payload_next = 1'b0;
                pos_next          = at_addr_last ? {POS_W{1'b0}} : pos_reg + POS_W'(1);
            end else begin
                pend_last_next    = at_data_last;
                pend_payload_next = !at_data_last && (pos_reg <= PAYLOAD_END) &&
                                    (verdict_reg == dsc_pkg::VERDICT_GOOD);
                pos_next          = at_data_last ? {POS_W{1'b0}} : pos_reg + POS_W'(1);
            end
        end

        // Feed the held byte to the CRC register, most significant bit first.
        if (state_reg == dsc_pkg::ST_SHIFT) begin
            shift_next   = {shift_reg[BW-2:0], 1'b0};
            bit_cnt_next = bit_cnt_reg + 3'd1;
        end

        // Close of the address area.
        if (verdict_set) begin
            if (!hdr_zero) begin
                verdict_next = dsc_pkg::VERDICT_BAD;
            end else if (sect_reg == dsc_pkg::SPARE_MARK) begin
                verdict_next = dsc_pkg::VERDICT_SPARE;
            end else begin
                verdict_next = dsc_pkg::VERDICT_GOOD;
            end
        end

        // Output register: a taken beat frees it, a new result fills it.
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (out_load) begin
            m_tvalid_next = 1'b1;
            if (pend_last_reg) begin
                m_tuser_next = dsc_pkg::RESULT_STATUS;
                m_tdata_next = {3'b000,
                                (status_val == dsc_pkg::STATUS_OK) ? lba_value :
                                                                     {dsc_pkg::LBA_W{1'b0}},
                                status_val, {BW{1'b0}}};
                verdict_next = dsc_pkg::VERDICT_NONE;
            end else begin
                m_tuser_next = dsc_pkg::RESULT_PAYLOAD;
                m_tdata_next = {3'b000, {dsc_pkg::LBA_W{1'b0}},
                                dsc_pkg::STATUS_OK, byte_reg};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= dsc_pkg::ST_IDLE;
            verdict_reg    <= dsc_pkg::VERDICT_NONE;
            pos_reg        <= {POS_W{1'b0}};
            open_area_reg  <= 1'b0;
            cyl_reg        <= {dsc_pkg::CYL_W{1'b0}};
            head_reg       <= {BW{1'b0}};
            sect_reg       <= {BW{1'b0}};
            head_count_reg <= dsc_pkg::HEAD_COUNT_RESET;
            spt_reg        <= dsc_pkg::SPT_RESET;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            verdict_reg    <= verdict_next;
            pos_reg        <= pos_next;
            open_area_reg  <= open_area_next;
            cyl_reg        <= cyl_next;
            head_reg       <= head_next;
            sect_reg       <= sect_next;
            head_count_reg <= head_count_next;
            spt_reg        <= spt_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
        bit_cnt_reg      <= bit_cnt_next;
        shift_reg        <= shift_next;
        byte_reg         <= byte_next;
        pend_area_reg    <= pend_area_next;
        pend_last_reg    <= pend_last_next;
        pend_payload_reg <= pend_payload_next;
        m_tdata_reg      <= m_tdata_next;
        m_tuser_reg      <= m_tuser_next;
    end

    // Address area check.
    dsc_crc_serial #(
        .W    (dsc_pkg::HDR_CRC_W),
        .POLY (dsc_pkg::HDR_POLY)
    ) u_hdr_crc (
        .aclk     (aclk),
        .init     (hdr_init),
        .shift_en (hdr_shift),
        .bit_in   (shift_reg[BW-1]),
        .is_zero  (hdr_zero)
    );

    // Data area check.
    dsc_crc_serial #(
        .W    (dsc_pkg::DAT_CRC_W),
        .POLY (dsc_pkg::DAT_POLY)
    ) u_dat_crc (
        .aclk     (aclk),
        .init     (dat_init),
        .shift_en (dat_shift),
        .bit_in   (shift_reg[BW-1]),
        .is_zero  (dat_zero)
    );

    // Logical block address from the captured header.
    always_comb begin
        lba_ops.cylinder          = cyl_reg;
        lba_ops.head              = head_reg;
        lba_ops.sector            = sect_reg;
        lba_ops.head_count        = head_count_reg;
        lba_ops.sectors_per_track = spt_reg;
    end

    dsc_lba_unit u_lba (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (lba_start),
        .operands (lba_ops),
        .done     (lba_done),
        .lba      (lba_value)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ===== rtl/dsc_crc_serial.sv =====
// Bit-serial MSB-first CRC register with a zero-residue flag.
module dsc_crc_serial #(
    parameter int           W    = dsc_pkg::HDR_CRC_W,
    parameter logic [W-1:0] POLY = dsc_pkg::HDR_POLY
) (
    input  logic aclk,
    input  logic init,
    input  logic shift_en,
    input  logic bit_in,
    output logic is_zero
);

    logic [W-1:0] crc_reg;
    logic [W-1:0] crc_next;
    logic         feedback;

    // One message bit per cycle while shift_en is high, through the feedback register.
    always_comb begin
        feedback = crc_reg[W-1] ^ bit_in;
        crc_next = crc_reg;
        if (init) begin
            crc_next = {W{1'b1}};
        end else if (shift_en) begin
            crc_next = {crc_reg[W-2:0], 1'b0} ^ (feedback ? POLY : {W{1'b0}});
        end
    end

    always_ff @(posedge aclk) begin
        crc_reg <= crc_next;
    end

    assign is_zero = (crc_reg == {W{1'b0}});

endmodule

// ===== rtl/dsc_lba_unit.sv =====
// Shift-and-add unit that forms (c*heads + h)*(spt-1) + s with saturation.
module dsc_lba_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  dsc_pkg::lba_operands_t        operands,
    output logic                          done,
    output logic [dsc_pkg::LBA_W-1:0]     lba
);

    localparam int AW = dsc_pkg::LBA_ACC_W;
    localparam int MW = dsc_pkg::LBA_MUL_W;
    localparam int SW = dsc_pkg::LBA_STEP_W;

    dsc_pkg::lba_state_t state_reg, state_next;
    logic [AW-1:0] acc_reg, acc_next;
    logic [AW-1:0] mcand_reg, mcand_next;
    logic [MW-1:0] mult_reg, mult_next;
    logic [SW-1:0] step_reg, step_next;
    logic          done_reg, done_next;
    logic [AW-1:0] acc_sum;
    logic [MW-1:0] usable;
    logic          last_step;
    logic          busy;

    // A track keeps one spare sector; fewer than two sectors leaves none usable.
    assign usable = (operands.sectors_per_track > MW'(1)) ?
                    (operands.sectors_per_track - MW'(1)) : {MW{1'b0}};

    assign acc_sum = acc_reg + (mult_reg[0] ? mcand_reg : {AW{1'b0}});

    // Next state of the sequencer.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            dsc_pkg::LBA_IDLE: begin
                if (start) begin
                    state_next = dsc_pkg::LBA_STAGE_A;
                end
            end
            dsc_pkg::LBA_STAGE_A: begin
                if (last_step) begin
                    state_next = dsc_pkg::LBA_STAGE_B;
                end
            end
            dsc_pkg::LBA_STAGE_B: begin
                if (last_step) begin
                    state_next = dsc_pkg::LBA_IDLE;
                end
            end
            default: begin
                state_next = dsc_pkg::LBA_IDLE;
            end
        endcase
    end

    // Decoded controls of the sequencer.
    always_comb begin
        busy      = (state_reg == dsc_pkg::LBA_STAGE_A) ||
                    (state_reg == dsc_pkg::LBA_STAGE_B);
        last_step = busy && (step_reg == {SW{1'b1}});
        done_next = (state_reg == dsc_pkg::LBA_STAGE_B) && last_step;
    end

    // Datapath: one multiplier bit per cycle, stage A for c*heads + h,
    // stage B for that times the usable sector count plus s.
    always_comb begin
        acc_next   = acc_reg;
        mcand_next = mcand_reg;
        mult_next  = mult_reg;
        step_next  = step_reg;
        if (start && (state_reg == dsc_pkg::LBA_IDLE)) begin
            acc_next   = AW'(operands.head);
            mcand_next = AW'(operands.cylinder);
            mult_next  = MW'(operands.head_count);
            step_next  = {SW{1'b0}};
        end else if (busy) begin
            step_next = step_reg + SW'(1);
            if ((state_reg == dsc_pkg::LBA_STAGE_A) && last_step) begin
                acc_next   = AW'(operands.sector);
                mcand_next = acc_sum;
                mult_next  = usable;
            end else begin
                acc_next   = acc_sum;
                mcand_next = {mcand_reg[AW-2:0], 1'b0};
                mult_next  = {1'b0, mult_reg[MW-1:1]};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= dsc_pkg::LBA_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
        acc_reg   <= acc_next;
        mcand_reg <= mcand_next;
        mult_reg  <= mult_next;
        step_reg  <= step_next;
    end

    assign done = done_reg;
    assign lba  = (acc_reg > AW'(dsc_pkg::LBA_MAX)) ? dsc_pkg::LBA_MAX :
                  acc_reg[dsc_pkg::LBA_W-1:0];

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the disk sector checker: sector stimulus, prediction and checking.

// One result beat as the block should return it.
typedef struct packed {
    logic                          kind;
    logic [dsc_pkg::BYTE_W-1:0]    payload;
    dsc_pkg::status_t              status;
    logic [dsc_pkg::LBA_W-1:0]     lba;
} sector_result_t;

// MSB-first CRC-16 over one byte.
function automatic logic [15:0] crc16_step(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    int i;
    c = crc ^ {b, 8'h00};
    for (i = 0; i < 8; i++) begin
        if (c[15]) c = (c << 1) ^ dsc_pkg::HDR_POLY;
        else c = c << 1;
    end
    return c;
endfunction

// MSB-first CRC-48 over one byte.
function automatic logic [47:0] crc48_step(logic [47:0] crc, logic [7:0] b);
    logic [47:0] c;
    int i;
    c = crc ^ {b, 40'h0};
    for (i = 0; i < 8; i++) begin
        if (c[47]) c = (c << 1) ^ dsc_pkg::DAT_POLY;
        else c = c << 1;
    end
    return c;
endfunction

// Tracks the sector state, predicts the result beats and checks what comes back.
class sector_scoreboard;
    logic [dsc_pkg::HEADS_W-1:0]   heads;
    logic [dsc_pkg::SPT_W-1:0]     spt;
    logic [15:0]                   hdr_crc;
    logic [47:0]                   dat_crc;
    int unsigned                   pos;
    logic                          open_area;
    logic [dsc_pkg::CYL_W-1:0]     cyl;
    logic [dsc_pkg::BYTE_W-1:0]    head_f;
    logic [dsc_pkg::BYTE_W-1:0]    sect_f;
    dsc_pkg::verdict_t             verdict;
    sector_result_t                expected_q[$];
    int                            errors;
    int                            payload_seen;
    int                            status_seen[4];

    function new();
        heads        = dsc_pkg::HEAD_COUNT_RESET;
        spt          = dsc_pkg::SPT_RESET;
        hdr_crc      = 16'hFFFF;
        dat_crc      = '1;
        pos          = 0;
        open_area    = 1'b0;
        cyl          = '0;
        head_f       = '0;
        sect_f       = '0;
        verdict      = dsc_pkg::VERDICT_NONE;
        errors       = 0;
        payload_seen = 0;
        foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function void write_reg(logic [dsc_pkg::CFG_INDEX_W-1:0] idx,
                            logic [dsc_pkg::CFG_DATA_W-1:0] val);
        if (idx == dsc_pkg::REG_HEAD_COUNT) heads = val[dsc_pkg::HEADS_W-1:0];
        else spt = val;
    endfunction

    // Logical block address from the captured fields, saturated to the field width.
    function logic [dsc_pkg::LBA_W-1:0] block_address();
        longint unsigned usable;
        longint unsigned v;
        usable = (spt > 1) ? longint'(spt) - 1 : 0;
        v = longint'(cyl) * longint'(heads) * usable + longint'(head_f) * usable
            + longint'(sect_f);
        if (v > longint'(dsc_pkg::LBA_MAX)) return dsc_pkg::LBA_MAX;
        return v[dsc_pkg::LBA_W-1:0];
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    // Advances the sector state by one accepted input beat.
    function void note_beat(logic [7:0] b, logic area, logic opens);
        int unsigned    idx;
        sector_result_t r;
        if (opens) begin
            open_area = area;
            pos = 1;
            if (!area) begin
                hdr_crc = 16'hFFFF;
                verdict = dsc_pkg::VERDICT_NONE;
            end else begin
                dat_crc = '1;
            end
            return;
        end
        if (pos == 0 || area != open_area) return;
        idx = pos;

        // Address area: capture the fields and settle the verdict on the last byte.
        if (!area) begin
            hdr_crc = crc16_step(hdr_crc, b);
            case (idx)
                1: cyl[15:8] = b;
                2: cyl[7:0] = b;
                3: head_f = b;
                4: sect_f = b;
                default: ;
            endcase
            if (idx >= dsc_pkg::ADDR_AREA_BYTES_DEF - 1) begin
                if (hdr_crc != 0) verdict = dsc_pkg::VERDICT_BAD;
                else if (sect_f == dsc_pkg::SPARE_MARK) verdict = dsc_pkg::VERDICT_SPARE;
                else verdict = dsc_pkg::VERDICT_GOOD;
                pos = 0;
            end else begin
                pos = idx + 1;
            end
            return;
        end

        // Data area: payload bytes under a good header, status on the last byte.
        dat_crc = crc48_step(dat_crc, b);
        r.payload = '0;
        r.lba = '0;
        r.status = dsc_pkg::STATUS_OK;
        if (idx >= dsc_pkg::DATA_AREA_BYTES_DEF - 1) begin
            r.kind = dsc_pkg::RESULT_STATUS;
            if (verdict == dsc_pkg::VERDICT_GOOD) begin
                if (dat_crc != 0) begin
                    r.status = dsc_pkg::STATUS_BAD_DATA;
                end else begin
                    r.status = dsc_pkg::STATUS_OK;
                    r.lba = block_address();
                end
            end else if (verdict == dsc_pkg::VERDICT_SPARE) begin
                r.status = dsc_pkg::STATUS_SPARE;
            end else begin
                r.status = dsc_pkg::STATUS_BAD_HEADER;
            end
            pos = 0;
            verdict = dsc_pkg::VERDICT_NONE;
            expected_q.push_back(r);
            return;
        end
        pos = idx + 1;
        if (idx <= dsc_pkg::SECTOR_BYTES_DEF && verdict == dsc_pkg::VERDICT_GOOD) begin
            r.kind = dsc_pkg::RESULT_PAYLOAD;
            r.payload = b;
            expected_q.push_back(r);
        end
    endfunction

    function void compare_field(string name, logic [63:0] exp, logic [63:0] act);
        if (act !== exp) begin
            $error("%s mismatch: expected %0h, actual %0h", name, exp, act);
            errors++;
        end
    endfunction

    // Checks one accepted result beat against the oldest expectation.
    function void check_result(logic kind, logic [dsc_pkg::OUT_TDATA_W-1:0] data);
        sector_result_t e;
        if (expected_q.size() == 0) begin
            $error("result beat with nothing expected: kind %0h data %0h", kind, data);
            errors++;
            return;
        end
        e = expected_q.pop_front();
        compare_field("result_kind", 64'(e.kind), 64'(kind));
        compare_field("payload_byte", 64'(e.payload), 64'(data[7:0]));
        compare_field("status", 64'(e.status), 64'(data[9:8]));
        compare_field("lba", 64'(e.lba), 64'(data[36:10]));
        compare_field("tdata fill", 64'(0), 64'(data[dsc_pkg::OUT_TDATA_W-1:37]));
        if (e.kind == dsc_pkg::RESULT_STATUS) status_seen[e.status]++;
        else payload_seen++;
    endfunction
endclass

module tb_top;

    localparam int PHASES        = 7;
    localparam int PHASE_BEATS   = 220;
    localparam int SETTLE_CYCLES = 40;
    localparam int DRAIN_LIMIT   = 200000;
    localparam int MAX_GAP       = 64;

    logic                               aclk      = 1'b0;
    logic                               aresetn   = 1'b0;
    logic                               s_tvalid  = 1'b0;
    logic                               s_tready;
    logic [dsc_pkg::IN_TDATA_W-1:0]     s_tdata   = '0;
    logic [dsc_pkg::IN_TUSER_W-1:0]     s_tuser   = '0;
    logic                               m_tvalid;
    logic                               m_tready  = 1'b0;
    logic [dsc_pkg::OUT_TDATA_W-1:0]    m_tdata;
    logic [dsc_pkg::OUT_TUSER_W-1:0]    m_tuser;
    logic                               cfg_valid = 1'b0;
    logic                               cfg_ready;
    logic [dsc_pkg::CFG_INDEX_W-1:0]    cfg_index = '0;
    logic [dsc_pkg::CFG_DATA_W-1:0]     cfg_data  = '0;

    sector_scoreboard sb;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int beats_sent     = 0;
    int settings_used  = 0;

    disk_sector_check_and_lba_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock generation.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Receiver back-pressure, changed on the falling edge.
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Result monitor: every accepted master beat is checked.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tuser[0], m_tdata);
    end

    function automatic int pick_gap();
        int g;
        g = 0;
        while (send_idle_pct > 0 && g < MAX_GAP && $urandom_range(99) < send_idle_pct) g++;
        return g;
    endfunction

    // Presents one input beat and waits for it to be taken.
    task automatic send_beat(input logic [7:0] v, input logic area, input logic opens);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        s_tuser  <= {opens, area};
        do @(posedge aclk); while (!s_tready);
        sb.note_beat(v, area, opens);
        beats_sent++;
        @(negedge aclk);
    endtask

    // A byte of an open area, now and then preceded by a stray beat of the other area.
    task automatic send_area_byte(input logic [7:0] v, input logic area);
        if ($urandom_range(99) < 3) send_beat(8'($urandom_range(255)), !area, 1'b0);
        send_beat(v, area, 1'b0);
    endtask

    // Mark plus the first count bytes of an address area with a valid CRC-16, one bit flipped if corrupt.
    task automatic send_address(input logic [15:0] cyl, input logic [7:0] head,
                                input logic [7:0] sect, input bit corrupt, input int count);
        logic [7:0]  hdr[1:7];
        logic [15:0] crc;
        int i;
        hdr[1] = cyl[15:8];
        hdr[2] = cyl[7:0];
        hdr[3] = head;
        hdr[4] = sect;
        hdr[5] = 8'($urandom_range(255));
        crc = 16'hFFFF;
        for (i = 1; i <= 5; i++) crc = crc16_step(crc, hdr[i]);
        hdr[6] = crc[15:8];
        hdr[7] = crc[7:0];
        if (corrupt) begin
            i = $urandom_range(7, 1);
            hdr[i] = hdr[i] ^ (8'h01 << $urandom_range(7));
        end
        send_beat(8'($urandom_range(255)), 1'b0, 1'b1);
        for (i = 1; i <= count; i++) send_area_byte(hdr[i], 1'b0);
    endtask

    // Complete data area: random payload followed by its CRC-48, one bit flipped if corrupt.
    task automatic send_data(input bit corrupt);
        logic [7:0]  body[1:dsc_pkg::DATA_AREA_BYTES_DEF-1];
        logic [47:0] crc;
        int i;
        crc = '1;
        for (i = 1; i <= dsc_pkg::SECTOR_BYTES_DEF; i++) begin
            body[i] = 8'($urandom_range(255));
            crc = crc48_step(crc, body[i]);
        end
        for (i = 0; i < 6; i++) body[dsc_pkg::SECTOR_BYTES_DEF + 1 + i] = crc[47 - 8*i -: 8];
        if (corrupt) begin
            i = $urandom_range(dsc_pkg::DATA_AREA_BYTES_DEF - 1, 1);
            body[i] = body[i] ^ (8'h01 << $urandom_range(7));
        end
        send_beat(8'($urandom_range(255)), 1'b1, 1'b1);
        for (i = 1; i < dsc_pkg::DATA_AREA_BYTES_DEF; i++) send_area_byte(body[i], 1'b1);
    endtask

    // Holds the input off until all expected results are back (or a guard runs out) and the block has settled.
    task automatic quiesce();
        int guard;
        guard = 0;
        s_tvalid <= 1'b0;
        while (sb.pending() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge aclk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Writes both registers back to back; only called with the block idle.
    task automatic configure(input logic [dsc_pkg::HEADS_W-1:0] h,
                             input logic [dsc_pkg::SPT_W-1:0] s);
        cfg_valid <= 1'b1;
        cfg_index <= dsc_pkg::REG_HEAD_COUNT;
        cfg_data  <= dsc_pkg::CFG_DATA_W'(h);
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(dsc_pkg::REG_HEAD_COUNT, dsc_pkg::CFG_DATA_W'(h));
        @(negedge aclk);
        cfg_index <= dsc_pkg::REG_SECTORS_PER_TRACK;
        cfg_data  <= s;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(dsc_pkg::REG_SECTORS_PER_TRACK, s);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // One random stretch of traffic: noise, a data area with a partial or no header, or a full sector.
    task automatic run_episode();
        int         pick;
        int         n;
        logic [15:0] c;
        logic [7:0]  h;
        logic [7:0]  s;
        pick = $urandom_range(99);
        if (pick < 15) begin
            n = $urandom_range(12, 3);
            repeat (n) send_beat(8'($urandom_range(255)), 1'($urandom_range(1)),
                                 $urandom_range(99) < 20);
        end else if (pick < 30) begin
            if ($urandom_range(1))
                send_address(16'($urandom_range(65535)), 8'($urandom_range(255)),
                             8'($urandom_range(255)), 1'b0, $urandom_range(6, 0));
            send_data($urandom_range(99) < 20);
        end else begin
            if ($urandom_range(99) < 8) quiesce();
            n = $urandom_range(9);
            c = (n == 0) ? 16'h0000 : (n == 1) ? 16'hFFFF : 16'($urandom_range(65535));
            n = $urandom_range(9);
            h = (n == 0) ? 8'h00 : (n == 1) ? 8'hFF : 8'($urandom_range(255));
            n = $urandom_range(9);
            s = (n < 2) ? dsc_pkg::SPARE_MARK : (n == 2) ? 8'h00 : 8'($urandom_range(254));
            send_address(c, h, s, $urandom_range(99) < 12, 7);
            send_data($urandom_range(99) < 20);
        end
    endtask

    // Run limit.
    initial begin
        #10_000_000;
        $display("tb_top NOT OK");
        $finish;
    end

    // Main sequence.
    initial begin
        int phase;
        int start;
        logic [dsc_pkg::HEADS_W-1:0] hc;
        logic [dsc_pkg::SPT_W-1:0]   spt;
        sb = new();
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed part under the reset settings: stray bytes, short areas, odd headers.
        send_beat(8'h00, 1'b0, 1'b0);
        send_beat(8'hFF, 1'b1, 1'b0);
        send_beat(8'hA5, 1'b1, 1'b1);
        send_beat(8'h3C, 1'b0, 1'b0);
        send_beat(8'hFF, 1'b1, 1'b0);
        send_address(16'hFFFF, 8'hFF, 8'h00, 1'b0, 3);
        send_address(16'h0000, 8'h00, dsc_pkg::SPARE_MARK, 1'b0, 7);
        send_address(16'h1234, 8'h01, 8'h05, 1'b1, 7);

        // Random phases, each with its own register setting and one of four idling patterns.
        for (phase = 0; phase < PHASES; phase++) begin
            quiesce();
            case (phase)
                0: begin hc = 5'd16; spt = 8'd128; end
                1: begin hc = 5'd1;  spt = 8'd2;   end
                2: begin hc = 5'd31; spt = 8'd255; end
                3: begin hc = 5'd0;  spt = 8'd0;   end
                4: begin hc = 5'($urandom_range(16, 1)); spt = 8'd1; end
                5: begin hc = 5'($urandom_range(16, 1)); spt = 8'($urandom_range(128, 2)); end
                default: begin hc = 5'($urandom_range(31)); spt = 8'($urandom_range(255)); end
            endcase
            configure(hc, spt);
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
                default: begin send_idle_pct = 31; recv_stall_pct = 31; end
            endcase
            start = beats_sent;
            while (beats_sent - start < PHASE_BEATS) run_episode();
        end

        quiesce();
        if (sb.pending() != 0) begin
            $error("%0d result beats never arrived", sb.pending());
            sb.errors++;
        end
        $display("Sent %0d input beats across %0d register settings and four idling patterns.",
                 beats_sent, settings_used + 1);
        $display("Checked %0d payload bytes; ok %0d, bad header %0d, bad data %0d, spare %0d.",
                 sb.payload_seen, sb.status_seen[dsc_pkg::STATUS_OK],
                 sb.status_seen[dsc_pkg::STATUS_BAD_HEADER],
                 sb.status_seen[dsc_pkg::STATUS_BAD_DATA],
                 sb.status_seen[dsc_pkg::STATUS_SPARE]);
        if (sb.errors == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
